// ----- hdl/tpsd_pkg.sv -----
// Shared types and constants for the tagged PCM section deinterleaver.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps

package tpsd_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 6;
   localparam int LENGTH_BITS_DEFAULT  = 24;

   localparam int TAG_BYTES            = 8;
   // Tag byte k sits in bits [8k+7:8k]: 11 AA 22 BB 33 CC 44 DD in arrival order.
   localparam logic [8*TAG_BYTES-1:0] SYNC_TAG = 64'hDD44_CC33_BB22_AA11;

   localparam int BYTE_W               = 8;
   localparam int SAMPLE_W             = 16;
   localparam int CHANNEL_W            = 3;
   localparam int SECTION_W            = 16;
   localparam int CH_COUNT_W           = 3;
   localparam int SECTION_BYTES_W      = 24;
   localparam int COUNT_W              = 5;
   localparam int RSP_TDATA_W          = 40;
   localparam int QUEUE_DEPTH          = 4;

   localparam int CSR_ADDR_W           = 3;
   localparam int CSR_DATA_W           = 32;

   localparam logic [CH_COUNT_W-1:0]      CHANNEL_COUNT_RESET = 3'd4;
   localparam logic [SECTION_BYTES_W-1:0] SECTION_BYTES_RESET = 24'd1474560;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_LENGTH = 2'd1,
      STATUS_NO_TAG = 2'd2
   } status_type;

   typedef enum logic {
      REG_CHANNEL_COUNT = 1'b0,
      REG_SECTION_BYTES = 1'b1
   } reg_index_type;

   // One queued job: a run of samples followed by an optional end marker.
   typedef struct packed {
      logic [COUNT_W-1:0]   sample_count;
      logic [SECTION_W-1:0] section_index;
      logic                 has_marker;
      status_type           status;
      logic                 stream_done;
   } job_ctrl_type;

endpackage

// ----- hdl/tagged_pcm_section_deinterleaver.sv -----
// Top level of the tagged PCM section deinterleaver: register port, front
// end, job queue and back end. Uses tpsd_pkg, tpsd_front, tpsd_queue, tpsd_back.
//
//   port group  | direction | carries
//   req_*       | in        | one stream byte per transfer, tlast = end of stream
//   rsp_*       | out       | one sample or section end marker per transfer
//   csr_*       | in/out    | channel_count at 0x0, section_bytes at 0x4
//
// The front end takes one byte every cycle while the job queue (4 jobs) has room.
// A byte that completes a frame and/or closes a section yields one job of up to
// seven results (one per active channel plus a marker); the back end sends one
// result per cycle unless rsp_tready stalls it, through its output register; each
// result is held in the job queue and then in the output register after its byte.
// Reset clears all control state at once; no clearing pass is needed.
// A stall on rsp_tready fills the queue and then drops req_tready.
`timescale 1ns / 1ps

module tagged_pcm_section_deinterleaver #(
   parameter int MAX_CHANNELS = tpsd_pkg::MAX_CHANNELS_DEFAULT,
   parameter int LENGTH_BITS  = tpsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tpsd_pkg::BYTE_W-1:0]      req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] sample, [18:16] channel, [34:19] section_index, [36:35] status,
   // [37] stream_done, [39:38] zero
   output logic [tpsd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tuser,   // [0] marker
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tpsd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tpsd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tpsd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import tpsd_pkg::*;

   localparam int SAMPLES_W = MAX_CHANNELS * SAMPLE_W;
   localparam int JOB_W     = $bits(job_ctrl_type) + SAMPLES_W;

   logic [CH_COUNT_W-1:0]      channel_count_ff;
   logic [SECTION_BYTES_W-1:0] section_bytes_ff;
   logic                       csr_write;
   reg_index_type              csr_index;

   logic                       job_space;
   logic                       job_push;
   job_ctrl_type               job_ctrl;
   logic [SAMPLES_W-1:0]       job_samples;
   logic                       head_valid;
   logic [JOB_W-1:0]           head_data;
   job_ctrl_type               head_ctrl;
   logic [SAMPLES_W-1:0]       head_samples;
   logic                       head_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CHANNEL_COUNT_RESET;
         section_bytes_ff <= SECTION_BYTES_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: channel_count_ff <= csr_pwdata[CH_COUNT_W-1:0];
            REG_SECTION_BYTES: section_bytes_ff <= csr_pwdata[SECTION_BYTES_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CHANNEL_COUNT: csr_prdata = CSR_DATA_W'(channel_count_ff);
         REG_SECTION_BYTES: csr_prdata = CSR_DATA_W'(section_bytes_ff);
      endcase
   end

   tpsd_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .LENGTH_BITS  (LENGTH_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .channel_count (channel_count_ff),
      .section_bytes (section_bytes_ff),
      .job_space     (job_space),
      .job_push      (job_push),
      .job_ctrl      (job_ctrl),
      .job_samples   (job_samples)
   );

   tpsd_queue #(
      .DATA_W (JOB_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  ({job_ctrl, job_samples}),
      .space      (job_space),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (head_pop)
   );

   assign head_ctrl    = head_data[JOB_W-1:SAMPLES_W];
   assign head_samples = head_data[SAMPLES_W-1:0];

   tpsd_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_ctrl    (head_ctrl),
      .head_samples (head_samples),
      .head_pop     (head_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

`ifndef SYNTHESIS
   // A marker always closes the results of its byte.
   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("section marker without tlast");

   // Samples carry neither a status nor the stream end flag.
   a_sample_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[36:35] == STATUS_OK && !rsp_tdata[37])
      else $error("sample result with marker fields set");

   // A no-tag report ends the stream and names section zero.
   a_no_tag_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[36:35] == STATUS_NO_TAG
      |-> rsp_tdata[37] && rsp_tdata[34:19] == '0)
      else $error("no-tag marker not closing the stream");

   // The queue only pops a job that is there.
   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("job queue popped while empty");
`endif

endmodule

// ----- hdl/tpsd_queue.sv -----
// Short job queue between the classifying front end and the result back end.
// Depends on tpsd_pkg only for the house style; the payload is a flat vector.
`timescale 1ns / 1ps

module tpsd_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              space,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data,
   input  logic              pop
);
   import tpsd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign space      = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/tpsd_front.sv -----
// Front end: takes one byte per transfer, hunts for the sync tag, assembles
// frames and section markers into jobs for the queue. Uses tpsd_pkg.
`timescale 1ns / 1ps

module tpsd_front #(
   parameter int MAX_CHANNELS = tpsd_pkg::MAX_CHANNELS_DEFAULT,
   parameter int LENGTH_BITS  = tpsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [tpsd_pkg::BYTE_W-1:0]                req_tdata,
   input  logic                                       req_tlast,
   input  logic [tpsd_pkg::CH_COUNT_W-1:0]            channel_count,
   input  logic [tpsd_pkg::SECTION_BYTES_W-1:0]       section_bytes,
   input  logic                                       job_space,
   output logic                                       job_push,
   output tpsd_pkg::job_ctrl_type                     job_ctrl,
   output logic [MAX_CHANNELS*tpsd_pkg::SAMPLE_W-1:0] job_samples
);
   import tpsd_pkg::*;

   localparam int STORE_DEPTH = 2 * MAX_CHANNELS - 1;
   localparam int FILL_W      = $clog2(2 * MAX_CHANNELS);
   localparam int FB_W        = FILL_W + 1;
   localparam int CH_W        = $clog2(MAX_CHANNELS + 1);
   localparam int WFILL_W     = $clog2(TAG_BYTES + 1);
   localparam int CMP_W       = (LENGTH_BITS > SECTION_BYTES_W) ? LENGTH_BITS
                                                                : SECTION_BYTES_W;

   logic [8*TAG_BYTES-1:0] win_ff, win_in;
   logic [WFILL_W-1:0]     wfill_ff, wfill_in;
   logic [BYTE_W-1:0]      store_ff [STORE_DEPTH];
   logic [FILL_W-1:0]      ffill_ff, ffill_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   locked_ff, locked_in;
   logic [SECTION_W-1:0]   secnum_ff, secnum_in;

   logic                   accept;
   logic                   have_old;
   logic [BYTE_W-1:0]      old_byte;
   logic                   match;
   logic [CH_W-1:0]        chans;
   logic [FB_W-1:0]        fbytes;
   logic                   take;
   logic                   frame_done;
   logic                   store_we;
   logic [LENGTH_BITS-1:0] len_inc;
   logic [LENGTH_BITS-1:0] len_now;
   logic                   mismatch;

   assign req_tready = job_space;
   assign accept     = req_tvalid && req_tready;
   assign have_old   = (wfill_ff == WFILL_W'(TAG_BYTES));
   assign old_byte   = win_ff[BYTE_W-1:0];

   // Clamp the channel count into 1..MAX_CHANNELS.
   always_comb begin
      if (channel_count == '0) begin
         chans = CH_W'(1);
      end else if (int'(channel_count) > MAX_CHANNELS) begin
         chans = CH_W'(MAX_CHANNELS);
      end else begin
         chans = CH_W'(channel_count);
      end
   end

   assign fbytes     = FB_W'({chans, 1'b0});
   assign take       = locked_ff && have_old;
   assign frame_done = take && ((FB_W'(ffill_ff) + FB_W'(1)) >= fbytes);
   assign store_we   = take && !frame_done && (int'(ffill_ff) < STORE_DEPTH);
   assign len_inc    = (&len_ff) ? len_ff : len_ff + 1'b1;
   assign len_now    = take ? len_inc : len_ff;
   assign mismatch   = (section_bytes != '0) &&
                       (CMP_W'(len_now) != CMP_W'(section_bytes));

   // Shift the arriving byte into the tag window.
   always_comb begin
      win_in = win_ff;
      if (have_old) begin
         win_in = {req_tdata, win_ff[8*TAG_BYTES-1:BYTE_W]};
      end else begin
         for (int k = 0; k < TAG_BYTES; k++) begin
            if (wfill_ff == WFILL_W'(k)) begin
               win_in[8*k +: 8] = req_tdata;
            end
         end
      end
   end

   assign match = (have_old || wfill_ff == WFILL_W'(TAG_BYTES - 1)) && (win_in == SYNC_TAG);

   // Frame bytes: held bytes first, the byte leaving the window fills the rest.
   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      logic [BYTE_W-1:0] lo_byte;
      logic [BYTE_W-1:0] hi_byte;
      assign lo_byte = (int'(ffill_ff) > 2 * c) ? store_ff[2*c] : old_byte;
      if (c < MAX_CHANNELS - 1) begin : g_hi_store
         assign hi_byte = (int'(ffill_ff) > 2 * c + 1) ? store_ff[2*c+1] : old_byte;
      end else begin : g_hi_arrive
         assign hi_byte = old_byte;
      end
      assign job_samples[SAMPLE_W*c +: SAMPLE_W] = {hi_byte, lo_byte};
   end

   always_comb begin
      wfill_in  = have_old ? wfill_ff : wfill_ff + 1'b1;
      ffill_in  = ffill_ff;
      len_in    = len_now;
      locked_in = locked_ff;
      secnum_in = secnum_ff;
      if (frame_done) begin
         ffill_in = '0;
      end else if (store_we) begin
         ffill_in = ffill_ff + 1'b1;
      end

      job_ctrl.sample_count  = frame_done ? COUNT_W'(chans) : '0;
      job_ctrl.section_index = secnum_ff;
      job_ctrl.has_marker    = 1'b0;
      job_ctrl.status        = STATUS_OK;
      job_ctrl.stream_done   = 1'b0;

      if (!locked_ff) begin
         job_ctrl.section_index = '0;
         if (match) begin
            locked_in = 1'b1;
            wfill_in  = '0;
            secnum_in = '0;
            len_in    = '0;
            ffill_in  = '0;
            if (req_tlast) begin
               job_ctrl.has_marker  = 1'b1;
               job_ctrl.stream_done = 1'b1;
               locked_in            = 1'b0;
            end
         end else if (req_tlast) begin
            job_ctrl.has_marker  = 1'b1;
            job_ctrl.status      = STATUS_NO_TAG;
            job_ctrl.stream_done = 1'b1;
            wfill_in             = '0;
            ffill_in             = '0;
            len_in               = '0;
            secnum_in            = '0;
         end
      end else begin
         if (match) begin
            job_ctrl.has_marker  = 1'b1;
            job_ctrl.status      = mismatch ? STATUS_LENGTH : STATUS_OK;
            job_ctrl.stream_done = req_tlast;
            secnum_in            = secnum_ff + 1'b1;
            len_in               = '0;
            ffill_in             = '0;
            wfill_in             = '0;
         end else if (req_tlast) begin
            job_ctrl.has_marker  = 1'b1;
            job_ctrl.stream_done = 1'b1;
         end
         // End of stream: drop the window tail and start over.
         if (req_tlast) begin
            wfill_in  = '0;
            ffill_in  = '0;
            len_in    = '0;
            locked_in = 1'b0;
            secnum_in = '0;
         end
      end
   end

   assign job_push = accept && (frame_done || job_ctrl.has_marker);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= '0;
         wfill_ff  <= '0;
         ffill_ff  <= '0;
         len_ff    <= '0;
         locked_ff <= 1'b0;
         secnum_ff <= '0;
      end else if (accept) begin
         win_ff    <= win_in;
         wfill_ff  <= wfill_in;
         ffill_ff  <= ffill_in;
         len_ff    <= len_in;
         locked_ff <= locked_in;
         secnum_ff <= secnum_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
         if (accept && store_we && ffill_ff == FILL_W'(k)) begin
            store_ff[k] <= old_byte;
         end
      end
   end

endmodule

// ----- hdl/tpsd_back.sv -----
// Back end: walks the job at the queue head and sends one result per transfer
// through an output register. Uses tpsd_pkg.
`timescale 1ns / 1ps

module tpsd_back #(
   parameter int MAX_CHANNELS = tpsd_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       head_valid,
   input  tpsd_pkg::job_ctrl_type                     head_ctrl,
   input  logic [MAX_CHANNELS*tpsd_pkg::SAMPLE_W-1:0] head_samples,
   output logic                                       head_pop,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [tpsd_pkg::RSP_TDATA_W-1:0]           rsp_tdata,
   output logic                                       rsp_tuser,
   output logic                                       rsp_tlast
);
   import tpsd_pkg::*;

   localparam int PAD_W = RSP_TDATA_W - (SAMPLE_W + CHANNEL_W + SECTION_W + 2 + 1);

   logic [COUNT_W-1:0]     idx_ff, idx_in;
   logic                   valid_ff;
   logic [RSP_TDATA_W-1:0] data_ff;
   logic                   user_ff;
   logic                   last_ff;

   logic                   load;
   logic                   is_sample;
   logic                   item_last;
   logic [SAMPLE_W-1:0]    sel_sample;
   logic [RSP_TDATA_W-1:0] data_in;

   assign load      = head_valid && (!valid_ff || rsp_tready);
   assign is_sample = (idx_ff < head_ctrl.sample_count);
   assign item_last = is_sample ? (idx_ff == head_ctrl.sample_count - 1'b1) &&
                                  !head_ctrl.has_marker
                                : 1'b1;
   assign head_pop  = load && item_last;
   assign idx_in    = item_last ? '0 : idx_ff + 1'b1;

   always_comb begin
      sel_sample = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (idx_ff == COUNT_W'(c)) begin
            sel_sample = head_samples[SAMPLE_W*c +: SAMPLE_W];
         end
      end
   end

   always_comb begin
      if (is_sample) begin
         data_in = {PAD_W'(0), 1'b0, STATUS_OK, head_ctrl.section_index,
                    idx_ff[CHANNEL_W-1:0], sel_sample};
      end else begin
         data_in = {PAD_W'(0), head_ctrl.stream_done, head_ctrl.status,
                    head_ctrl.section_index, CHANNEL_W'(0), SAMPLE_W'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= idx_in;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= !is_sample;
         last_ff <= item_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule
